/* hdl/fpv_pkg.sv */
// Package with constants, codes and the CRC-32 byte update for the frame packet validator.
`timescale 1ns / 1ps

package fpv_pkg;

    localparam int COUNT_BITS = 24;
    localparam int HDR_LEN = 24;
    localparam int HDR_IDX_W = $clog2(HDR_LEN);
    localparam int CMP_W = 33;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [7:0] MAGIC_0 = 8'h50;
    localparam logic [7:0] MAGIC_1 = 8'h44;
    localparam logic [7:0] MAGIC_2 = 8'h50;
    localparam logic [7:0] MAGIC_3 = 8'h53;

    localparam logic [7:0]  FORMAT_VERSION_RST = 8'd1;
    localparam logic [15:0] FRAME_WIDTH_RST = 16'd400;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd240;
    localparam logic [22:0] PAYLOAD_LENGTH_RST = 23'd12000;

    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_FORMAT_VERSION = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;
    localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd3;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_MAGIC,
        ST_VERSION,
        ST_SHAPE,
        ST_LENGTH,
        ST_CRC
    } status_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

/* hdl/frame_packet_validator_crc32.sv */
// Top level of the frame packet validator: header capture, CRC-32 and result checks.
`timescale 1ns / 1ps

// The block takes one packet byte per cycle with no gaps between packets. Each byte
// updates the byte count and either the 24-byte header store (first 24 bytes) or the
// byte-wide CRC-32 (later bytes) in the cycle it is accepted; on the byte marked last,
// the header, length and CRC checks are worked out in that same cycle and the result
// appears in the output register on the next cycle. The rate is set by the single-stage
// byte-wide CRC update and check logic: one item is taken every cycle while the output
// side accepts results, and input keeps flowing while a result waits if taken in the same cycle.
module frame_packet_validator_crc32 (
    input  logic                         clk,
    input  logic                         rst_n,
    // s_tdata: data_byte [7:0]
    input  logic [7:0]                   s_tdata,
    input  logic                         s_tlast,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // m_tdata: status [2:0], revision [34:3], zero fill [39:35]
    output logic [39:0]                  m_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fpv_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import fpv_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [7:0]            format_version_reg;
    logic [15:0]           frame_width_reg;
    logic [15:0]           frame_height_reg;
    logic [22:0]           payload_length_reg;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [31:0]           crc_reg;
    logic [31:0]           crc_next;
    logic [7:0]            hdr_reg [HDR_LEN];
    logic [7:0]            hdr_next [HDR_LEN];

    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    status_t               status_reg;
    status_t               status_next;
    logic [31:0]           revision_reg;
    logic [31:0]           revision_next;

    logic                  in_accept;
    logic                  hdr_write;
    logic                  cfg_write;
    logic [CMP_W-1:0]      total_len;
    logic [CMP_W-1:0]      count_ext;

    assign pready = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_version_reg <= FORMAT_VERSION_RST;
            frame_width_reg <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            payload_length_reg <= PAYLOAD_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_FORMAT_VERSION: format_version_reg <= pwdata[7:0];
                REG_FRAME_WIDTH:    frame_width_reg <= pwdata[15:0];
                REG_FRAME_HEIGHT:   frame_height_reg <= pwdata[15:0];
                REG_PAYLOAD_LENGTH: payload_length_reg <= pwdata[22:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FORMAT_VERSION: prdata = {24'd0, format_version_reg};
            REG_FRAME_WIDTH:    prdata = {16'd0, frame_width_reg};
            REG_FRAME_HEIGHT:   prdata = {16'd0, frame_height_reg};
            REG_PAYLOAD_LENGTH: prdata = {9'd0, payload_length_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign hdr_write = (count_reg < COUNT_BITS'(HDR_LEN));

    // Per-item update of count, CRC and header as they stand after this byte.
    always_comb
    begin
        count_next = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        crc_next = hdr_write ? crc_reg : crc32_byte(crc_reg, s_tdata);
        for (int i = 0; i < HDR_LEN; i++)
        begin
            hdr_next[i] = (hdr_write && (count_reg[HDR_IDX_W-1:0] == HDR_IDX_W'(i)))
                          ? s_tdata : hdr_reg[i];
        end
    end

    assign total_len = CMP_W'(HDR_LEN) + CMP_W'(payload_length_reg);
    assign count_ext = CMP_W'(count_next);

    // The first failing check sets the status.
    always_comb
    begin
        if (count_next < COUNT_BITS'(HDR_LEN))
        begin
            status_next = ST_SHORT;
        end
        else if (hdr_next[0] != MAGIC_0 || hdr_next[1] != MAGIC_1 ||
                 hdr_next[2] != MAGIC_2 || hdr_next[3] != MAGIC_3)
        begin
            status_next = ST_MAGIC;
        end
        else if (hdr_next[4] != format_version_reg)
        begin
            status_next = ST_VERSION;
        end
        else if ({hdr_next[6], hdr_next[7]} != 16'(HDR_LEN) ||
                 {hdr_next[8], hdr_next[9]} != frame_width_reg ||
                 {hdr_next[10], hdr_next[11]} != frame_height_reg)
        begin
            status_next = ST_SHAPE;
        end
        else if ({hdr_next[16], hdr_next[17], hdr_next[18], hdr_next[19]} !=
                 {9'd0, payload_length_reg} ||
                 count_next == COUNT_MAX || count_ext != total_len)
        begin
            status_next = ST_LENGTH;
        end
        else if ((crc_next ^ CRC_INIT) !=
                 {hdr_next[20], hdr_next[21], hdr_next[22], hdr_next[23]})
        begin
            status_next = ST_CRC;
        end
        else
        begin
            status_next = ST_OK;
        end
        revision_next = (status_next == ST_OK)
                        ? {hdr_next[12], hdr_next[13], hdr_next[14], hdr_next[15]} : 32'd0;
    end

    always_comb
    begin
        if (in_accept && s_tlast)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg <= CRC_INIT;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (in_accept)
            begin
                if (s_tlast)
                begin
                    count_reg <= '0;
                    crc_reg <= CRC_INIT;
                end
                else
                begin
                    count_reg <= count_next;
                    crc_reg <= crc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < HDR_LEN; i++)
            begin
                hdr_reg[i] <= hdr_next[i];
            end
            if (s_tlast)
            begin
                status_reg <= status_next;
                revision_reg <= revision_next;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {5'd0, revision_reg, status_reg};

`ifndef NO_ASSERTIONS
    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_tlast |=> m_tvalid)
        else $error("No result after the last byte of a packet.");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_tlast |=> count_reg == '0 && crc_reg == CRC_INIT)
        else $error("Packet state not cleared after a result.");

    a_revision_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[34:3] == 32'd0)
        else $error("Revision is not zero on an error status.");

    a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !s_tlast && count_reg != COUNT_MAX |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Byte count did not advance on an accepted item.");
`endif

endmodule

/* sim/frame_packet_validator_crc32_tb.sv */
// Self-checking testbench for the frame packet validator, driven by directed and random packets.
`timescale 1ns / 1ps

module frame_packet_validator_crc32_tb;

    import fpv_pkg::*;

    typedef enum int {
        PK_GOOD,
        PK_SHORT,
        PK_MAGIC,
        PK_VERSION,
        PK_HLEN,
        PK_WIDTH,
        PK_HEIGHT,
        PK_PLEN,
        PK_LONG,
        PK_TRUNC,
        PK_CRC,
        PK_NOISE
    } pkt_kind_t;

    typedef struct {
        bit          fixed;
        status_t     st;
        logic [31:0] rev;
    } verdict_t;

    typedef struct {
        pkt_kind_t   kind;
        bit          new_cfg;
        int          param;
        int          fill;
        logic [31:0] rev;
        bit          fixed;
        status_t     st;
    } plan_row_t;

    localparam int N_PLAN = 16;

    logic                clk;
    logic                rst_n;
    logic [7:0]          s_tdata;
    logic                s_tlast;
    logic                s_tvalid;
    logic                s_tready;
    logic [39:0]         m_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Predictor state and its copy of the registers.
    logic [COUNT_BITS-1:0] seen_bytes;
    logic [7:0]            hdr_copy [0:HDR_LEN-1];
    logic [31:0]           run_crc;
    logic [7:0]            cfg_ver;
    logic [15:0]           cfg_w;
    logic [15:0]           cfg_h;
    logic [22:0]           cfg_plen;

    verdict_t    expected_q [$];
    verdict_t    typed_answers [$];
    verdict_t    ans;
    verdict_t    got_exp;
    status_t     pred_st;
    logic [7:0]  pkt [$];
    plan_row_t   plan [N_PLAN];
    int          send_idle;
    int          recv_idle;
    int          hold_left;
    int          mismatches;

    frame_packet_validator_crc32 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] crc_next(logic [31:0] acc, logic [7:0] b);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            r = (r[0] ^ b[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [31:0] hdr_word(int at);
        return {hdr_copy[at], hdr_copy[at + 1], hdr_copy[at + 2], hdr_copy[at + 3]};
    endfunction

    function automatic status_t packet_status();
        logic [24:0] total;
        total = 25'(HDR_LEN) + {2'b00, cfg_plen};
        if (seen_bytes < HDR_LEN)
            return ST_SHORT;
        if (hdr_copy[0] != MAGIC_0 || hdr_copy[1] != MAGIC_1 ||
            hdr_copy[2] != MAGIC_2 || hdr_copy[3] != MAGIC_3)
            return ST_MAGIC;
        if (hdr_copy[4] != cfg_ver)
            return ST_VERSION;
        if ({hdr_copy[6], hdr_copy[7]} != 16'(HDR_LEN) ||
            {hdr_copy[8], hdr_copy[9]} != cfg_w ||
            {hdr_copy[10], hdr_copy[11]} != cfg_h)
            return ST_SHAPE;
        if (hdr_word(16) != {9'd0, cfg_plen} || seen_bytes == {COUNT_BITS{1'b1}} ||
            {1'b0, seen_bytes} != total)
            return ST_LENGTH;
        if ((run_crc ^ CRC_INIT) != hdr_word(20))
            return ST_CRC;
        return ST_OK;
    endfunction

    // Input side: every accepted item advances the predictor.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            if (seen_bytes < HDR_LEN)
                hdr_copy[seen_bytes[HDR_IDX_W-1:0]] = s_tdata;
            else
                run_crc = crc_next(run_crc, s_tdata);
            if (seen_bytes != {COUNT_BITS{1'b1}})
                seen_bytes = seen_bytes + 1'b1;
            if (s_tlast)
            begin
                pred_st = packet_status();
                got_exp.fixed = 1'b0;
                got_exp.st = pred_st;
                got_exp.rev = (pred_st == ST_OK) ? hdr_word(12) : 32'd0;
                if (typed_answers.size() != 0)
                begin
                    ans = typed_answers.pop_front();
                    if (ans.fixed)
                    begin
                        got_exp.st = ans.st;
                        got_exp.rev = ans.rev;
                    end
                end
                expected_q.push_back(got_exp);
                seen_bytes = '0;
                run_crc = CRC_INIT;
            end
        end
    end

    // Output side: each accepted item is compared with the oldest expectation.
    always @(posedge clk)
    begin : check_out
        verdict_t want;
        status_t  st_got;
        st_got = status_t'(m_tdata[2:0]);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("%0t: unexpected result status=%0d revision=%h",
                             $realtime, st_got, m_tdata[34:3]);
            end
            else
            begin
                want = expected_q.pop_front();
                if (st_got != want.st || m_tdata[34:3] != want.rev)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: status exp %0d got %0d, revision exp %h got %h",
                                 $realtime, want.st, st_got, want.rev, m_tdata[34:3]);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    task automatic send_byte(logic [7:0] b, bit last);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    task automatic send_packet();
        for (int k = 0; k < pkt.size(); k++)
        begin
            send_byte(pkt[k], k == pkt.size() - 1);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_FORMAT_VERSION: cfg_ver = value[7:0];
            REG_FRAME_WIDTH:    cfg_w = value[15:0];
            REG_FRAME_HEIGHT:   cfg_h = value[15:0];
            REG_PAYLOAD_LENGTH: cfg_plen = value[22:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] ver, logic [15:0] w, logic [15:0] h,
                              logic [22:0] plen);
        logic [31:0] junk;
        wait_idle();
        junk = $urandom();
        write_reg(REG_FORMAT_VERSION, {junk[31:8], ver});
        write_reg(REG_FRAME_WIDTH, {junk[15:0], w});
        write_reg(REG_FRAME_HEIGHT, {junk[31:16], h});
        write_reg(REG_PAYLOAD_LENGTH, {junk[8:0], plen});
    endtask

    task automatic build_packet(pkt_kind_t kind, int param, int fill, logic [31:0] rev);
        int          n_pay;
        int          keep;
        logic [31:0] c;
        logic [31:0] plen_word;
        logic [7:0]  flip;
        pkt.delete();
        flip = 8'h01 << $urandom_range(0, 7);
        if (kind == PK_NOISE)
        begin
            repeat ($urandom_range(1, 48))
                pkt.push_back(8'($urandom()));
            return;
        end
        n_pay = (cfg_plen > 64) ? $urandom_range(0, 40) : int'(cfg_plen);
        plen_word = {9'd0, cfg_plen};
        pkt.push_back(MAGIC_0);
        pkt.push_back(MAGIC_1);
        pkt.push_back(MAGIC_2);
        pkt.push_back(MAGIC_3);
        pkt.push_back(cfg_ver);
        pkt.push_back((kind == PK_GOOD && param >= 0) ? 8'(param) : 8'($urandom()));
        pkt.push_back(8'h00);
        pkt.push_back(8'(HDR_LEN));
        pkt.push_back(cfg_w[15:8]);
        pkt.push_back(cfg_w[7:0]);
        pkt.push_back(cfg_h[15:8]);
        pkt.push_back(cfg_h[7:0]);
        for (int k = 3; k >= 0; k--)
            pkt.push_back(rev[8*k +: 8]);
        for (int k = 3; k >= 0; k--)
            pkt.push_back(plen_word[8*k +: 8]);
        repeat (4) pkt.push_back(8'h00);
        repeat (n_pay) pkt.push_back((fill < 0) ? 8'($urandom()) : 8'(fill));
        c = CRC_INIT;
        for (int k = HDR_LEN; k < pkt.size(); k++)
            c = crc_next(c, pkt[k]);
        c = c ^ CRC_INIT;
        for (int k = 0; k < 4; k++)
            pkt[20 + k] = c[8*(3 - k) +: 8];
        case (kind)
            PK_SHORT:
            begin
                keep = (param > 0) ? param : $urandom_range(1, HDR_LEN - 1);
                while (pkt.size() > keep)
                    void'(pkt.pop_back());
            end
            PK_MAGIC:   begin keep = $urandom_range(0, 3); pkt[keep] = pkt[keep] ^ flip; end
            PK_VERSION: pkt[4] = pkt[4] ^ flip;
            PK_HLEN:    begin keep = $urandom_range(6, 7); pkt[keep] = pkt[keep] ^ flip; end
            PK_WIDTH:   begin keep = $urandom_range(8, 9); pkt[keep] = pkt[keep] ^ flip; end
            PK_HEIGHT:  begin keep = $urandom_range(10, 11); pkt[keep] = pkt[keep] ^ flip; end
            PK_PLEN:    begin keep = $urandom_range(16, 19); pkt[keep] = pkt[keep] ^ flip; end
            PK_LONG:
            begin
                repeat ($urandom_range(1, 5))
                    pkt.push_back(8'($urandom()));
            end
            PK_TRUNC:
            begin
                if (pkt.size() > HDR_LEN)
                    repeat ($urandom_range(1, pkt.size() - HDR_LEN))
                        void'(pkt.pop_back());
            end
            PK_CRC:
            begin
                keep = $urandom_range(20, pkt.size() - 1);
                pkt[keep] = pkt[keep] ^ flip;
            end
            default: ;
        endcase
    endtask

    // Mostly well-formed packets with random content, the rest broken or noise.
    task automatic run_phase(int min_bytes, int min_pkts);
        int        n_bytes;
        int        n_pkts;
        int        r;
        pkt_kind_t kind;
        n_bytes = 0;
        n_pkts = 0;
        while (n_bytes < min_bytes || n_pkts < min_pkts)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                kind = PK_GOOD;
            else if (r < 85)
                kind = pkt_kind_t'($urandom_range(PK_SHORT, PK_CRC));
            else
                kind = PK_NOISE;
            build_packet(kind, -1, -1, $urandom());
            ans.fixed = 1'b0;
            ans.st = ST_OK;
            ans.rev = 32'd0;
            typed_answers.push_back(ans);
            send_packet();
            n_bytes = n_bytes + pkt.size();
            n_pkts = n_pkts + 1;
        end
    endtask

    function automatic plan_row_t mk(pkt_kind_t kind, bit new_cfg, int param, int fill,
                                     logic [31:0] rev, bit fixed, status_t st);
        plan_row_t row;
        row.kind = kind;
        row.new_cfg = new_cfg;
        row.param = param;
        row.fill = fill;
        row.rev = rev;
        row.fixed = fixed;
        row.st = st;
        return row;
    endfunction

    initial
    begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = 32'd0;
        send_idle = 15;
        recv_idle = 81;
        hold_left = 0;
        mismatches = 0;
        seen_bytes = '0;
        run_crc = CRC_INIT;
        for (int k = 0; k < HDR_LEN; k++)
            hdr_copy[k] = 8'd0;
        cfg_ver = FORMAT_VERSION_RST;
        cfg_w = FRAME_WIDTH_RST;
        cfg_h = FRAME_HEIGHT_RST;
        cfg_plen = PAYLOAD_LENGTH_RST;

        // The first row runs on the values after reset; its payload is far shorter than the
        // reset length, so the total length check fails.
        plan[0]  = mk(PK_GOOD,    1'b0, 8'h00, 8'h00, 32'h0102_0304, 1'b1, ST_LENGTH);
        plan[1]  = mk(PK_GOOD,    1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, ST_OK);
        plan[2]  = mk(PK_GOOD,    1'b0, 8'h00, -1,    32'h0000_0000, 1'b1, ST_OK);
        plan[3]  = mk(PK_GOOD,    1'b0, -1,    -1,    32'h8BAD_1F2E, 1'b0, ST_OK);
        plan[4]  = mk(PK_SHORT,   1'b0, 1,     -1,    32'h1111_2222, 1'b1, ST_SHORT);
        plan[5]  = mk(PK_SHORT,   1'b0, 23,    -1,    32'h3333_4444, 1'b1, ST_SHORT);
        plan[6]  = mk(PK_MAGIC,   1'b0, 0,     -1,    32'h5555_6666, 1'b1, ST_MAGIC);
        plan[7]  = mk(PK_VERSION, 1'b0, 0,     -1,    32'h7777_8888, 1'b1, ST_VERSION);
        plan[8]  = mk(PK_HLEN,    1'b0, 0,     -1,    32'h9999_AAAA, 1'b1, ST_SHAPE);
        plan[9]  = mk(PK_WIDTH,   1'b0, 0,     -1,    32'hBBBB_CCCC, 1'b1, ST_SHAPE);
        plan[10] = mk(PK_HEIGHT,  1'b0, 0,     -1,    32'hDDDD_EEEE, 1'b1, ST_SHAPE);
        plan[11] = mk(PK_PLEN,    1'b0, 0,     -1,    32'h1234_5678, 1'b1, ST_LENGTH);
        plan[12] = mk(PK_LONG,    1'b0, 0,     -1,    32'h2345_6789, 1'b1, ST_LENGTH);
        plan[13] = mk(PK_TRUNC,   1'b0, 0,     -1,    32'h3456_789A, 1'b1, ST_LENGTH);
        plan[14] = mk(PK_CRC,     1'b0, 0,     -1,    32'h4567_89AB, 1'b1, ST_CRC);
        plan[15] = mk(PK_SHORT,   1'b0, 12,    -1,    32'h5678_9ABC, 1'b1, ST_SHORT);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_PLAN; i++)
        begin
            if (plan[i].new_cfg)
                set_config(8'hA5, 16'h5A3C, 16'hC3A5, 23'd5);
            build_packet(plan[i].kind, plan[i].param, plan[i].fill, plan[i].rev);
            ans.fixed = plan[i].fixed;
            ans.st = plan[i].st;
            ans.rev = (plan[i].st == ST_OK) ? plan[i].rev : 32'd0;
            typed_answers.push_back(ans);
            send_packet();
        end

        set_config(8'($urandom()), 16'($urandom()), 16'($urandom()),
                   23'($urandom_range(0, 31)));
        run_phase(150, 5);

        send_idle = 81;
        recv_idle = 15;
        set_config(8'hFF, 16'hFFFF, 16'hFFFF, 23'd0);
        run_phase(150, 5);

        send_idle = 0;
        recv_idle = 0;
        set_config(8'h00, 16'h0000, 16'h0000, 23'($urandom_range(1, 31)));
        @(posedge clk);
        hold_left = 400;
        run_phase(150, 5);

        set_config(8'($urandom()), 16'($urandom()), 16'($urandom()), 23'h7F_FFFF);
        run_phase(100, 3);

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
